// ===== rtl/sonar_scalar_kalman_filter_core_defines.svh =====
// assertion macros for the sonar kalman filter checker
`ifndef SONAR_SCALAR_KALMAN_FILTER_CORE_DEFINES_SVH
`define SONAR_SCALAR_KALMAN_FILTER_CORE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define SSKF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SSKF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sskf_pkg.sv =====
// types, constants and microcode table of the sonar kalman filter
`timescale 1ns / 1ps
package sskf_pkg;

  localparam int unsigned NumChannelsDef = 4;

  localparam int unsigned ChW       = 2;
  localparam int unsigned MmW       = 16;
  localparam int unsigned RangeW    = 24;
  localparam int unsigned RangeFrac = 16;
  localparam int unsigned NoiseW    = 32;
  localparam int unsigned GainFrac  = 24;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 32;

  // radix-2 divider for the gain: 25 quotient bits, remainder below a 33-bit divisor
  localparam int unsigned QuoW  = GainFrac + 1;
  localparam int unsigned RemW  = NoiseW + 1;
  localparam int unsigned ConvW = MmW + RangeFrac;
  localparam int unsigned CntW  = $clog2(QuoW);
  localparam int unsigned ProdW = QuoW + NoiseW;

  // divide by 1000 as a multiply by 2^38 / 1000 rounded up, exact for any 32-bit dividend
  localparam int unsigned RecipW    = 29;
  localparam int unsigned RecipSh   = 38;
  localparam int unsigned ConvProdW = RecipSh + RangeW;

  localparam logic [CntW-1:0]     DivLast     = CntW'(QuoW - 1);
  localparam logic [RecipW-1:0]   MmRecip     = RecipW'(274877907);
  localparam logic [ConvW-1:0]    ConvRound   = ConvW'(500);
  localparam logic [QuoW-1:0]     OneQ24      = QuoW'(1) << GainFrac;
  localparam logic [NoiseW-1:0]   CovRst      = NoiseW'(1) << GainFrac;
  localparam logic [NoiseW-1:0]   ProcNoiseRst = NoiseW'(167772);
  localparam logic [NoiseW-1:0]   MeasNoiseRst = NoiseW'(1677722);
  localparam logic [RangeW-1:0]   MaxRangeRst  = RangeW'(32768);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_USE_FILTER,
    CFG_PROCESS_NOISE,
    CFG_MEAS_NOISE,
    CFG_MAX_RANGE
  } cfg_idx_e;

  typedef enum logic [3:0] {
    UOP_NOP,
    UOP_IDLE,
    UOP_DIV_STEP,
    UOP_CONV_DONE,
    UOP_PREDICT,
    UOP_GAIN_START,
    UOP_GAIN_DONE,
    UOP_MUL_EST,
    UOP_UPD_EST,
    UOP_UPD_COV,
    UOP_EMIT
  } uop_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_NO_INPUT,
    COND_DIV_BUSY,
    COND_NO_FILTER,
    COND_OUT_BUSY
  } cond_e;

  typedef logic [3:0] pc_t;

  // jump to target when cond holds, else fall through (or back to idle when fin)
  typedef struct packed {
    uop_e  op;
    cond_e cond;
    pc_t   target;
    logic  fin;
  } uword_t;

  localparam pc_t PcIdle      = 4'd0;
  localparam pc_t PcConvDone  = 4'd1;
  localparam pc_t PcPredict   = 4'd2;
  localparam pc_t PcGainStart = 4'd3;
  localparam pc_t PcGainDiv   = 4'd4;
  localparam pc_t PcGainDone  = 4'd5;
  localparam pc_t PcMulEst    = 4'd6;
  localparam pc_t PcUpdEst    = 4'd7;
  localparam pc_t PcUpdCov    = 4'd8;
  localparam pc_t PcEmit      = 4'd9;

  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    w = '{op: UOP_NOP, cond: COND_NEVER, target: PcIdle, fin: 1'b1};
    case (pc)
      PcIdle:      w = '{op: UOP_IDLE,       cond: COND_NO_INPUT,  target: PcIdle,    fin: 1'b0};
      PcConvDone:  w = '{op: UOP_CONV_DONE,  cond: COND_NO_FILTER, target: PcEmit,    fin: 1'b0};
      PcPredict:   w = '{op: UOP_PREDICT,    cond: COND_NEVER,     target: PcIdle,    fin: 1'b0};
      PcGainStart: w = '{op: UOP_GAIN_START, cond: COND_NEVER,     target: PcIdle,    fin: 1'b0};
      PcGainDiv:   w = '{op: UOP_DIV_STEP,   cond: COND_DIV_BUSY,  target: PcGainDiv, fin: 1'b0};
      PcGainDone:  w = '{op: UOP_GAIN_DONE,  cond: COND_NEVER,     target: PcIdle,    fin: 1'b0};
      PcMulEst:    w = '{op: UOP_MUL_EST,    cond: COND_NEVER,     target: PcIdle,    fin: 1'b0};
      PcUpdEst:    w = '{op: UOP_UPD_EST,    cond: COND_NEVER,     target: PcIdle,    fin: 1'b0};
      PcUpdCov:    w = '{op: UOP_UPD_COV,    cond: COND_NEVER,     target: PcIdle,    fin: 1'b0};
      PcEmit:      w = '{op: UOP_EMIT,       cond: COND_OUT_BUSY,  target: PcEmit,    fin: 1'b1};
      default:     w = '{op: UOP_NOP,        cond: COND_NEVER,     target: PcIdle,    fin: 1'b1};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/sskf_if.sv =====
// valid/ready channel interfaces for readings, results and register writes
`timescale 1ns / 1ps
interface sskf_in_if import sskf_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [ChW-1:0] channel;
  logic [MmW-1:0] raw_mm;

  modport source (output valid, output channel, output raw_mm, input ready);
  modport sink   (input valid, input channel, input raw_mm, output ready);
endinterface

interface sskf_out_if import sskf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ChW-1:0]    channel_out;
  logic [RangeW-1:0] range_out;
  logic              clamped;

  modport source (output valid, output channel_out, output range_out, output clamped,
                  input ready);
  modport sink   (input valid, input channel_out, input range_out, input clamped,
                  output ready);
endinterface

interface sskf_cfg_if import sskf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/sonar_scalar_kalman_filter_core.sv =====
// Sonar range filter: one reading in, one range out, per-channel scalar Kalman state.
// in_i carries a channel number and a raw echo distance in mm; out_o returns the
// channel, the range in metres (Q8.16) and a clamped flag. cfg_i writes the four
// registers (use_filter, process noise, measurement noise, max range) and is always
// ready; write it only while no reading is in flight.
// A small microcode program drives the datapath: the mm to metre conversion is a
// multiply by the reciprocal of 1000, the gain steps a radix-2 divider (25 steps)
// and one 25x32 multiplier serves both state updates. An unfiltered reading's result
// is loaded after the conversion; a filtered one passes conversion, prediction,
// gain divide, two multiplies and state write-back first. Input is ready again in
// the same cycle as the result becomes valid.
// The result sits in an output register; input is ready again as soon as it is
// loaded, so a stalled receiver only holds the sequencer at its final step when a
// second result is due and the register is still full.
// Reset sets every channel's estimate to zero and covariance to 1.0, loads the
// register defaults and leaves the output channel empty.
`timescale 1ns / 1ps
module sonar_scalar_kalman_filter_core import sskf_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = NumChannelsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sskf_in_if.sink    in_i,
  sskf_out_if.source out_o,
  sskf_cfg_if.sink   cfg_i
);

  // channel numbers above the input width never reach the store
  localparam int unsigned NumStore = (NUM_CHANNELS < (1 << ChW)) ? NUM_CHANNELS : (1 << ChW);
  localparam int unsigned IdxW     = (NumStore > 1) ? $clog2(NumStore) : 1;

  // registers
  logic              use_filter_q;
  logic [NoiseW-1:0] proc_noise_q;
  logic [NoiseW-1:0] meas_noise_q;
  logic [RangeW-1:0] max_range_q;

  logic [RangeW-1:0] est_q [NumStore];
  logic [NoiseW-1:0] cov_q [NumStore];

  // sequencer
  pc_t    pc_q, pc_d;
  uword_t uw;
  logic   cond_hit;

  // datapath
  logic [ChW-1:0]    ch_q, ch_d;
  logic [MmW-1:0]    mm_q, mm_d;
  logic [RangeW-1:0] m_q, m_d;
  logic [RangeW-1:0] x_q, x_d;
  logic [RangeW-1:0] res_q, res_d;
  logic [RangeW-1:0] mag_q, mag_d;
  logic              dir_q, dir_d;
  logic [NoiseW-1:0] nowp_q, nowp_d;
  logic [QuoW-1:0]   gain_q, gain_d;
  logic [ProdW-1:0]  prod_q, prod_d;
  logic [RemW-1:0]   rem_q, rem_d;
  logic [QuoW-1:0]   quo_q, quo_d;
  logic [RemW-1:0]   dvs_q, dvs_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  logic [ChW-1:0]    out_ch_q;
  logic [RangeW-1:0] out_range_q;
  logic              out_clamped_q;
  logic              out_valid_q;

  logic                 in_xfer;
  logic                 out_free;
  logic                 out_load;
  logic                 ch_ok;
  logic [IdxW-1:0]      idx;
  logic [ConvW-1:0]     conv_num;
  logic [ConvProdW-1:0] conv_prod;
  logic [RangeW-1:0]    conv_m;
  logic [RemW:0]        rem_sh;
  logic                 div_ge;
  logic [RemW:0]        rem_sub;
  logic [RemW-1:0]      rem_nx;
  logic [QuoW-1:0]      quo_nx;
  logic [NoiseW:0]      cov_sum;
  logic [RemW-1:0]      gain_den;
  logic [QuoW-1:0]      mul_a;
  logic [NoiseW-1:0]    mul_b;
  logic [ProdW-1:0]     mul_p;
  logic [RangeW-1:0]    est_step;
  logic [RangeW-1:0]    est_new;
  logic [NoiseW-1:0]    cov_new;
  logic                 est_we;
  logic                 cov_we;
  logic                 clamp;

  assign uw       = ucode(pc_q);
  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign ch_ok    = (32'(ch_q) < NUM_CHANNELS);
  assign idx      = ch_q[IdxW-1:0];

  assign in_i.ready  = (uw.op == UOP_IDLE);
  assign cfg_i.ready = 1'b1;

  assign out_o.valid       = out_valid_q;
  assign out_o.channel_out = out_ch_q;
  assign out_o.range_out   = out_range_q;
  assign out_o.clamped     = out_clamped_q;

  // mm to Q8.16 metres, rounded: (mm * 65536 + 500) / 1000
  assign conv_num  = {mm_q, {RangeFrac{1'b0}}} + ConvRound;
  assign conv_prod = ConvProdW'(conv_num) * ConvProdW'(MmRecip);
  assign conv_m    = conv_prod[RecipSh +: RangeW];

  // one restoring divide step: next dividend bit comes out of the quotient shifter
  assign rem_sh  = {rem_q, quo_q[QuoW-1]};
  assign div_ge  = (rem_sh >= {1'b0, dvs_q});
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign rem_nx  = div_ge ? rem_sub[RemW-1:0] : rem_sh[RemW-1:0];
  assign quo_nx  = {quo_q[QuoW-2:0], div_ge};

  assign cov_sum  = {1'b0, cov_q[idx]} + {1'b0, proc_noise_q};
  assign gain_den = {1'b0, nowp_q} + {1'b0, meas_noise_q};

  // shared multiplier: gain * |m - x|, then (1 - gain) * nowP
  assign mul_a = (uw.op == UOP_UPD_EST) ? (OneQ24 - gain_q) : gain_q;
  assign mul_b = (uw.op == UOP_UPD_EST) ? nowp_q : NoiseW'(mag_q);
  assign mul_p = mul_a * mul_b;

  assign est_step = prod_q[GainFrac +: RangeW];
  assign est_new  = dir_q ? (x_q + est_step) : (x_q - est_step);
  assign cov_new  = prod_q[GainFrac +: NoiseW];

  assign clamp = (res_q == '0) || (res_q > max_range_q);

  always_comb begin
    case (uw.cond)
      COND_NEVER:     cond_hit = 1'b0;
      COND_NO_INPUT:  cond_hit = !in_i.valid;
      COND_DIV_BUSY:  cond_hit = (cnt_q != '0);
      COND_NO_FILTER: cond_hit = !(use_filter_q && ch_ok);
      COND_OUT_BUSY:  cond_hit = !out_free;
      default:        cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    if (cond_hit) begin
      pc_d = uw.target;
    end else if (uw.fin) begin
      pc_d = PcIdle;
    end else begin
      pc_d = pc_q + 1'b1;
    end
  end

  always_comb begin
    ch_d     = ch_q;
    mm_d     = mm_q;
    m_d      = m_q;
    x_d      = x_q;
    res_d    = res_q;
    mag_d    = mag_q;
    dir_d    = dir_q;
    nowp_d   = nowp_q;
    gain_d   = gain_q;
    prod_d   = prod_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    dvs_d    = dvs_q;
    cnt_d    = cnt_q;
    est_we   = 1'b0;
    cov_we   = 1'b0;
    out_load = 1'b0;
    case (uw.op)
      UOP_IDLE: begin
        if (in_xfer) begin
          ch_d = in_i.channel;
          mm_d = in_i.raw_mm;
        end
      end
      UOP_DIV_STEP: begin
        rem_d = rem_nx;
        quo_d = quo_nx;
        cnt_d = cnt_q - 1'b1;
      end
      UOP_CONV_DONE: begin
        m_d   = conv_m;
        res_d = conv_m;
      end
      UOP_PREDICT: begin
        x_d    = est_q[idx];
        nowp_d = cov_sum[NoiseW] ? '1 : cov_sum[NoiseW-1:0];
      end
      UOP_GAIN_START: begin
        // dividend is nowP << 24; its top bits seed the remainder
        rem_d = RemW'(nowp_q[NoiseW-1:1]);
        quo_d = {nowp_q[0], {(QuoW-1){1'b0}}};
        dvs_d = gain_den;
        cnt_d = DivLast;
      end
      UOP_GAIN_DONE: begin
        gain_d = (dvs_q == '0) ? '0 : quo_q;
        dir_d  = (m_q >= x_q);
        mag_d  = (m_q >= x_q) ? (m_q - x_q) : (x_q - m_q);
      end
      UOP_MUL_EST: begin
        prod_d = mul_p;
      end
      UOP_UPD_EST: begin
        est_we = 1'b1;
        res_d  = est_new;
        prod_d = mul_p;
      end
      UOP_UPD_COV: begin
        cov_we = 1'b1;
      end
      UOP_EMIT: begin
        out_load = out_free;
      end
      UOP_NOP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= PcIdle;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      out_valid_q <= out_load || (out_valid_q && !out_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q   <= ch_d;
    mm_q   <= mm_d;
    m_q    <= m_d;
    x_q    <= x_d;
    res_q  <= res_d;
    mag_q  <= mag_d;
    dir_q  <= dir_d;
    nowp_q <= nowp_d;
    gain_q <= gain_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    dvs_q  <= dvs_d;
    cnt_q  <= cnt_d;
    if (out_load) begin
      out_ch_q      <= ch_q;
      out_range_q   <= clamp ? max_range_q : res_q;
      out_clamped_q <= clamp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumStore; i++) begin
        est_q[i] <= '0;
        cov_q[i] <= CovRst;
      end
    end else begin
      if (est_we) begin
        est_q[idx] <= est_new;
      end
      if (cov_we) begin
        cov_q[idx] <= cov_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_filter_q <= 1'b0;
      proc_noise_q <= ProcNoiseRst;
      meas_noise_q <= MeasNoiseRst;
      max_range_q  <= MaxRangeRst;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_USE_FILTER:    use_filter_q <= cfg_i.data[0];
        CFG_PROCESS_NOISE: proc_noise_q <= cfg_i.data[NoiseW-1:0];
        CFG_MEAS_NOISE:    meas_noise_q <= cfg_i.data[NoiseW-1:0];
        CFG_MAX_RANGE:     max_range_q  <= cfg_i.data[RangeW-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/sskf_checker.sv =====
// port-level checks for the sonar kalman filter, bound to the top level
`timescale 1ns / 1ps
`include "sonar_scalar_kalman_filter_core_defines.svh"
module sskf_checker import sskf_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [RangeW-1:0] range_out_i,
  input logic              clamped_i,
  input logic              cfg_valid_i,
  input logic              cfg_ready_i
);

  // one reading at a time: the sequencer leaves idle right after a transfer
  `SSKF_ASSERT_NEXT(a_in_one_at_a_time, in_valid_i && in_ready_i, !in_ready_i, "ready after transfer")

  // an unreplaced range is never zero
  `SSKF_ASSERT_NOW(a_zero_is_clamped, out_valid_i && !clamped_i, range_out_i != '0, "zero range not clamped")

  `SSKF_ASSERT_NEXT(a_out_held, out_valid_i && !out_ready_i, out_valid_i && $stable(range_out_i) && $stable(clamped_i), "result dropped under stall")

  `SSKF_ASSERT_NOW(a_cfg_ready, cfg_valid_i, cfg_ready_i, "register write refused")

endmodule

bind sonar_scalar_kalman_filter_core sskf_checker u_sskf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .range_out_i (out_o.range_out),
  .clamped_i   (out_o.clamped),
  .cfg_valid_i (cfg_i.valid),
  .cfg_ready_i (cfg_i.ready)
);

// ===== bench/sonar_scalar_kalman_filter_core_tb.sv =====
// self-checking testbench for the sonar scalar kalman filter core
`timescale 1ns / 1ps
module sonar_scalar_kalman_filter_core_tb;
  import sskf_pkg::*;

  localparam int unsigned NumCh       = NumChannelsDef;
  localparam int unsigned SettleTicks = 80;
  localparam int unsigned TimeoutTick = 1000000;
  localparam int unsigned RandItems   = 1850;
  localparam int unsigned BlockItems  = 100;

  typedef struct packed {
    logic [ChW-1:0]    channel;
    logic [RangeW-1:0] range;
    logic              clamped;
  } range_result_t;

  logic clk_i;
  logic rst_ni;

  sskf_in_if  in_if ();
  sskf_out_if out_if ();
  sskf_cfg_if cfg_if ();

  sonar_scalar_kalman_filter_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // shadow of the registers and of the per-channel filter state
  logic              filter_en;
  logic [NoiseW-1:0] q_noise;
  logic [NoiseW-1:0] r_noise;
  logic [RangeW-1:0] max_rng;
  logic [RangeW-1:0] est_q [NumCh];
  logic [NoiseW-1:0] cov_q [NumCh];

  range_result_t pending_ranges [$];
  int unsigned   error_count;
  int unsigned   tx_idle_pct;
  int unsigned   rx_idle_pct;
  logic [MmW-1:0] target_mm [NumCh];

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  function automatic void reset_shadow();
    filter_en = 1'b0;
    q_noise   = ProcNoiseRst;
    r_noise   = MeasNoiseRst;
    max_rng   = MaxRangeRst;
    for (int i = 0; i < NumCh; i++) begin
      est_q[i] = '0;
      cov_q[i] = CovRst;
    end
  endfunction

  // converts one reading, filters it when enabled for a valid channel and clamps it, advancing the shadow state
  function automatic range_result_t predict_range(input logic [ChW-1:0] ch,
                                                  input logic [MmW-1:0] mm);
    range_result_t res;
    logic [63:0]   conv;
    logic [63:0]   nowp;
    logic [63:0]   denom;
    logic [63:0]   gain;
    logic [63:0]   step;
    logic [RangeW-1:0] x;
    logic [RangeW-1:0] r;
    conv = ((64'(mm) << RangeFrac) + 64'd500) / 64'd1000;
    r = conv[RangeW-1:0];
    if (filter_en && ch < NumCh) begin
      nowp = 64'(cov_q[ch]) + 64'(q_noise);
      if (nowp > 64'hFFFF_FFFF) nowp = 64'hFFFF_FFFF;
      denom = nowp + 64'(r_noise);
      gain = (denom == 64'd0) ? 64'd0 : (nowp << GainFrac) / denom;
      x = est_q[ch];
      if (r >= x) begin
        step = (gain * 64'(r - x)) >> GainFrac;
        r = x + step[RangeW-1:0];
      end else begin
        step = (gain * 64'(x - r)) >> GainFrac;
        r = x - step[RangeW-1:0];
      end
      est_q[ch] = r;
      step = (((64'd1 << GainFrac) - gain) * nowp) >> GainFrac;
      cov_q[ch] = step[NoiseW-1:0];
    end
    res.channel = ch;
    res.clamped = 1'b0;
    if (r == '0 || r > max_rng) begin
      r = max_rng;
      res.clamped = 1'b1;
    end
    res.range = r;
    return res;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    range_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_ranges.size() == 0) begin
        $error("unexpected result: channel_out %0d range_out %0d clamped %0d",
               out_if.channel_out, out_if.range_out, out_if.clamped);
        error_count++;
      end else begin
        want = pending_ranges.pop_front();
        if (out_if.channel_out !== want.channel) begin
          $error("channel_out: expected %0d, got %0d", want.channel, out_if.channel_out);
          error_count++;
        end
        if (out_if.range_out !== want.range) begin
          $error("range_out: expected %0d, got %0d", want.range, out_if.range_out);
          error_count++;
        end
        if (out_if.clamped !== want.clamped) begin
          $error("clamped: expected %0d, got %0d", want.clamped, out_if.clamped);
          error_count++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  initial begin
    repeat (TimeoutTick) @(posedge clk_i);
    $display("tb: failure");
    $finish;
  end

  // entered and left just after a falling edge; valid stays high for a following item
  task automatic send_reading(input logic [ChW-1:0] ch, input logic [MmW-1:0] mm);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.channel <= ch;
    in_if.raw_mm  <= mm;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    pending_ranges.push_back(predict_range(ch, mm));
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (pending_ranges.size() != 0) @(negedge clk_i);
    repeat (SettleTicks) @(negedge clk_i);
  endtask

  // only called with the block idle
  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (cfg_if.ready !== 1'b1) @(posedge clk_i);
    case (idx)
      CFG_USE_FILTER:    filter_en = value[0];
      CFG_PROCESS_NOISE: q_noise   = value;
      CFG_MEAS_NOISE:    r_noise   = value;
      CFG_MAX_RANGE:     max_rng   = value[RangeW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic test_passthrough();
    send_reading(2'd0, 16'd0);
    send_reading(2'd1, 16'd1);
    send_reading(2'd2, 16'd499);
    send_reading(2'd3, 16'd500);
    send_reading(2'd0, 16'd501);
    send_reading(2'd1, 16'hFFFF);
    drain_results();
    // upper data bits are not part of the register
    write_reg(CFG_MAX_RANGE, 32'hFFFF_FFFF);
    send_reading(2'd3, 16'hFFFF);
    send_reading(2'd2, 16'h8000);
    drain_results();
    write_reg(CFG_MAX_RANGE, 32'd0);
    send_reading(2'd1, 16'd1000);
    drain_results();
  endtask

  task automatic test_filter_defaults();
    write_reg(CFG_USE_FILTER, 32'hFFFF_FFFF);
    write_reg(CFG_MAX_RANGE, 32'h00FF_FFFF);
    send_reading(2'd0, 16'd1000);
    send_reading(2'd0, 16'd1000);
    send_reading(2'd0, 16'd1000);
    send_reading(2'd1, 16'd0);
    send_reading(2'd2, 16'hFFFF);
    send_reading(2'd3, 16'd200);
    send_reading(2'd3, 16'hFFFF);
    drain_results();
  endtask

  // gain of one drives covariance to zero, after which the gain divisor is zero
  task automatic test_zero_noise();
    write_reg(CFG_PROCESS_NOISE, 32'd0);
    write_reg(CFG_MEAS_NOISE, 32'd0);
    send_reading(2'd0, 16'd2000);
    send_reading(2'd0, 16'd3000);
    send_reading(2'd1, 16'd500);
    drain_results();
  endtask

  task automatic test_noise_saturation();
    write_reg(CFG_PROCESS_NOISE, 32'hFFFF_FFFF);
    write_reg(CFG_MEAS_NOISE, 32'hFFFF_FFFF);
    send_reading(2'd0, 16'd100);
    send_reading(2'd1, 16'hFFFF);
    send_reading(2'd2, 16'd0);
    drain_results();
    write_reg(CFG_MEAS_NOISE, 32'd0);
    send_reading(2'd3, 16'd4321);
    drain_results();
  endtask

  function automatic logic [NoiseW-1:0] pick_noise();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return $urandom_range(0, 32'h0100_0000);
      3:       return $urandom();
      default: return $urandom_range(0, 32'h0040_0000);
    endcase
  endfunction

  task automatic randomise_settings();
    logic [CfgDataW-1:0] junk;
    logic [RangeW-1:0]   lim;
    junk = $urandom();
    write_reg(CFG_USE_FILTER, {junk[CfgDataW-1:1], ($urandom_range(0, 99) < 75)});
    write_reg(CFG_PROCESS_NOISE, pick_noise());
    write_reg(CFG_MEAS_NOISE, pick_noise());
    case ($urandom_range(0, 9))
      0:       lim = '0;
      1, 2:    lim = '1;
      3, 4:    lim = RangeW'($urandom());
      default: lim = RangeW'($urandom_range(0, 6000) * 66);
    endcase
    junk = $urandom();
    write_reg(CFG_MAX_RANGE, {junk[CfgDataW-1:RangeW], lim});
  endtask

  // mostly noisy readings around a per-channel target so the filters track
  function automatic logic [MmW-1:0] pick_reading(input logic [ChW-1:0] ch);
    int signed v;
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return '1;
      2, 3:    return MmW'($urandom());
      4:       begin
        target_mm[ch] = MmW'($urandom_range(20, 6000));
        return target_mm[ch];
      end
      default: begin
        v = int'(target_mm[ch]) + $urandom_range(0, 200) - 100;
        if (v < 0) v = 0;
        return MmW'(v);
      end
    endcase
  endfunction

  task automatic run_random_phase(input int unsigned tx_pct, input int unsigned rx_pct,
                                  input int unsigned n_items);
    logic [ChW-1:0] ch;
    int unsigned    sent;
    int unsigned    hold_at;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent = 0;
    while (sent < n_items) begin
      drain_results();
      randomise_settings();
      hold_at = $urandom_range(10, BlockItems - 10);
      for (int i = 0; i < BlockItems && sent < n_items; i++) begin
        // sender holds off until the block has returned everything
        if (i == hold_at) drain_results();
        ch = ChW'($urandom_range(0, NumCh - 1));
        send_reading(ch, pick_reading(ch));
        sent++;
      end
    end
    drain_results();
  endtask

  task automatic test_random_tracking();
    for (int i = 0; i < NumCh; i++) target_mm[i] = MmW'($urandom_range(20, 6000));
    run_random_phase(38, 78, RandItems / 3);
    run_random_phase(78, 38, RandItems / 3);
    run_random_phase(0, 0, RandItems - 2 * (RandItems / 3));
  endtask

  initial begin
    error_count   = 0;
    tx_idle_pct   = 20;
    rx_idle_pct   = 20;
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.channel = '0;
    in_if.raw_mm  = '0;
    out_if.ready  = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = CFG_USE_FILTER;
    cfg_if.data   = '0;
    reset_shadow();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_passthrough();
    test_filter_defaults();
    test_zero_noise();
    test_noise_saturation();
    test_random_tracking();

    drain_results();
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sskf_pkg.sv
rtl/sskf_if.sv
rtl/sonar_scalar_kalman_filter_core.sv
rtl/sskf_checker.sv
bench/sonar_scalar_kalman_filter_core_tb.sv
